// File: rtl/vnorm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;

  localparam int DEF_MAX_DIMS = 4;
  localparam int LANES        = 4;
  localparam int COMP_W       = 16;
  localparam int MAG_W        = COMP_W + 1;
  localparam int SUM_W        = 2 * MAG_W;
  localparam int FRAC_SHIFT   = 16;
  localparam int ROOT_W       = 25;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int SQ_REM_W     = ROOT_W + 2;
  localparam int DIV_REM_W    = ROOT_W + 1;
  localparam int Q_W          = 15;
  localparam int DIV_PRESHIFT = 22 - Q_W;
  localparam int UNIT_ONE     = 16384;
  localparam int DIMS_W       = 3;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [Q_W-1:0]   quot_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic [LANES-1:0] used;
    logic             one_dim;
    logic             zero;
    mag_t [LANES-1:0] mag;
  } meta_t;

  // Saturate a magnitude to one and apply the sign.
  function automatic logic signed [COMP_W-1:0] to_field(input quot_t q, input logic neg);
    logic [COMP_W-1:0] m;
    begin
      m = (q > quot_t'(UNIT_ONE)) ? COMP_W'(UNIT_ONE) : COMP_W'(q);
      to_field = neg ? -$signed(m) : $signed(m);
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/vnorm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vnorm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         dims;
  logic signed [15:0] comp_x;
  logic signed [15:0] comp_y;
  logic signed [15:0] comp_z;
  logic signed [15:0] comp_w;
  modport source(output valid, dims, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink(input valid, dims, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface
`default_nettype wire

// File: rtl/vnorm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vnorm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic signed [15:0] unit_w;
  logic               zero_vector;
  modport source(output valid, unit_x, unit_y, unit_z, unit_w, zero_vector, input ready);
  modport sink(input valid, unit_x, unit_y, unit_z, unit_w, zero_vector, output ready);
endinterface
`default_nettype wire

// File: rtl/vnorm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module vnorm_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [vnorm_pkg::RAD_W-1:0] in_rad,
  input  wire vnorm_pkg::meta_t            in_meta,
  output logic                             out_valid,
  output logic [vnorm_pkg::ROOT_W-1:0]     out_root,
  output vnorm_pkg::meta_t                 out_meta
);
  import vnorm_pkg::*;

  logic                valid [ROOT_W];
  logic [RAD_W-1:0]    rad   [ROOT_W];
  logic [SQ_REM_W-1:0] rem   [ROOT_W];
  logic [ROOT_W-1:0]   root  [ROOT_W];
  meta_t               meta  [ROOT_W];

  // One root bit per stage, two radicand bits consumed per stage.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                p_valid;
    logic [RAD_W-1:0]    p_rad;
    logic [SQ_REM_W-1:0] p_rem;
    logic [ROOT_W-1:0]   p_root;
    meta_t               p_meta;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rad   = in_rad;
      assign p_rem   = '0;
      assign p_root  = '0;
      assign p_meta  = in_meta;
    end else begin : g_next
      assign p_valid = valid[k-1];
      assign p_rad   = rad[k-1];
      assign p_rem   = rem[k-1];
      assign p_root  = root[k-1];
      assign p_meta  = meta[k-1];
    end

    always_comb begin
      rem_sh = {p_rem[SQ_REM_W-3:0], p_rad[RAD_W-1 -: 2]};
      trial  = {p_root, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv) begin
        valid[k] <= p_valid;
      end
      if (adv) begin
        rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
        rem[k]  <= ge ? rem_sh - trial : rem_sh;
        root[k] <= {p_root[ROOT_W-2:0], ge};
        meta[k] <= p_meta;
      end
    end
  end

  assign out_valid = valid[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_meta  = meta[ROOT_W-1];

endmodule
`default_nettype wire

// File: rtl/vnorm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vnorm_div #(
  parameter int MAX_DIMS = vnorm_pkg::DEF_MAX_DIMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic [vnorm_pkg::ROOT_W-1:0] in_divisor,
  input  wire vnorm_pkg::meta_t             in_meta,
  output logic                              out_valid,
  output vnorm_pkg::quot_t [vnorm_pkg::LANES-1:0] out_quot,
  output vnorm_pkg::meta_t                  out_meta
);
  import vnorm_pkg::*;

  logic                         valid [Q_W];
  logic [ROOT_W-1:0]            dvs   [Q_W];
  meta_t                        meta  [Q_W];
  logic [LANES-1:0][DIV_REM_W-1:0] rem [Q_W];
  quot_t [LANES-1:0]            quot  [Q_W];

  // Restoring division, one quotient bit per stage; the low dividend bits are zero.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic                             p_valid;
    logic [ROOT_W-1:0]                p_dvs;
    meta_t                            p_meta;
    logic [LANES-1:0][DIV_REM_W-1:0]  p_rem;
    quot_t [LANES-1:0]                p_quot;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_dvs   = in_divisor;
      assign p_meta  = in_meta;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign p_rem[l]  = DIV_REM_W'({in_meta.mag[l], DIV_PRESHIFT'(0)});
        assign p_quot[l] = '0;
      end
    end else begin : g_next
      assign p_valid = valid[k-1];
      assign p_dvs   = dvs[k-1];
      assign p_meta  = meta[k-1];
      assign p_rem   = rem[k-1];
      assign p_quot  = quot[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (l < MAX_DIMS) begin : g_on
        logic [DIV_REM_W-1:0] rem_sh;
        logic                 ge;
        always_comb begin
          rem_sh = {p_rem[l][DIV_REM_W-2:0], 1'b0};
          ge     = rem_sh >= {1'b0, p_dvs};
        end
        always_ff @(posedge clk) begin
          if (adv) begin
            rem[k][l]  <= ge ? rem_sh - {1'b0, p_dvs} : rem_sh;
            quot[k][l] <= {p_quot[l][Q_W-2:0], ge};
          end
        end
      end else begin : g_off
        always_ff @(posedge clk) begin
          if (adv) begin
            rem[k][l]  <= '0;
            quot[k][l] <= '0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv) begin
        valid[k] <= p_valid;
      end
      if (adv) begin
        dvs[k]  <= p_dvs;
        meta[k] <= p_meta;
      end
    end
  end

  assign out_valid = valid[Q_W-1];
  assign out_quot  = quot[Q_W-1];
  assign out_meta  = meta[Q_W-1];

endmodule
`default_nettype wire

// File: rtl/vector_normalize_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 43 register stages (2 front, 25 square-root, 15 divide,
// 1 output register); the first is loaded at the accept edge.
// Throughput: one item per cycle; the whole pipe holds while the output is stalled.
// Reset: synchronous, active high; clears every stage valid bit, the payload is not reset.
module vector_normalize_core #(
  parameter int MAX_DIMS = vnorm_pkg::DEF_MAX_DIMS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  vnorm_in_if.sink    vec,
  vnorm_out_if.source unit
);
  import vnorm_pkg::*;

  // Global advance: move every stage when the output slot is free or being taken.
  logic adv;
  assign adv       = !unit.valid || unit.ready;
  assign vec.ready = adv;

  // Front stage 1: magnitudes, signs, lane usage, squares.
  logic [DIMS_W-1:0] n_clamp;
  logic signed [COMP_W-1:0] comp [LANES];
  meta_t             meta_in;
  logic [SUM_W-1:0]  sq_in [LANES];

  assign comp[0] = vec.comp_x;
  assign comp[1] = vec.comp_y;
  assign comp[2] = vec.comp_z;
  assign comp[3] = vec.comp_w;

  always_comb begin
    // Treat zero as one, saturate at MAX_DIMS.
    if (vec.dims == '0) begin
      n_clamp = DIMS_W'(1);
    end else if (vec.dims > DIMS_W'(MAX_DIMS)) begin
      n_clamp = DIMS_W'(MAX_DIMS);
    end else begin
      n_clamp = vec.dims;
    end
    meta_in         = '0;
    meta_in.one_dim = n_clamp == DIMS_W'(1);
    for (int i = 0; i < LANES; i++) begin
      meta_in.neg[i]  = comp[i][COMP_W-1];
      meta_in.mag[i]  = comp[i][COMP_W-1] ? MAG_W'(-$signed({comp[i][COMP_W-1], comp[i]}))
                                          : MAG_W'(comp[i]);
      meta_in.used[i] = DIMS_W'(i) < n_clamp;
    end
  end

  logic             v1;
  meta_t            meta1;
  logic [SUM_W-1:0] sq1 [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_sq
    // Zero the square of an unused lane so it drops out of the sum.
    assign sq_in[i] = meta_in.used[i] ? SUM_W'(meta_in.mag[i] * meta_in.mag[i]) : '0;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq1[i] <= sq_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= vec.valid;
    end
    if (adv) begin
      meta1 <= meta_in;
    end
  end

  // Front stage 2: sum of squares and the zero-vector flag.
  logic             v2;
  meta_t            meta2;
  logic [SUM_W-1:0] sum2;
  logic [SUM_W-1:0] sum_next;
  meta_t            meta2_next;

  always_comb begin
    sum_next = (sq1[0] + sq1[1]) + (sq1[2] + sq1[3]);
    meta2_next      = meta1;
    meta2_next.zero = !meta1.one_dim && (sum_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      sum2  <= sum_next;
      meta2 <= meta2_next;
    end
  end

  // Length: floor(sqrt(sum << 16)).
  logic              sq_valid;
  logic [ROOT_W-1:0] len;
  meta_t             sq_meta;

  vnorm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v2),
    .in_rad   (RAD_W'({sum2, FRAC_SHIFT'(0)})),
    .in_meta  (meta2),
    .out_valid(sq_valid),
    .out_root (len),
    .out_meta (sq_meta)
  );

  // Quotients: (mag << 22) / len per lane.
  logic              dv_valid;
  quot_t [LANES-1:0] quot;
  meta_t             dv_meta;

  vnorm_div #(.MAX_DIMS(MAX_DIMS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_divisor(len),
    .in_meta   (sq_meta),
    .out_valid (dv_valid),
    .out_quot  (quot),
    .out_meta  (dv_meta)
  );

  // Output register: apply sign, one-dimension, zero-vector and unused-lane overrides.
  logic signed [COMP_W-1:0] res [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (dv_meta.one_dim) begin
        res[i] = (i == 0) ? to_field(quot_t'(UNIT_ONE), dv_meta.neg[0]) : '0;
      end else if (dv_meta.zero || !dv_meta.used[i]) begin
        res[i] = '0;
      end else begin
        res[i] = to_field(quot[i], dv_meta.neg[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit.valid <= 1'b0;
    end else if (adv) begin
      unit.valid <= dv_valid;
    end
    if (adv) begin
      unit.unit_x      <= res[0];
      unit.unit_y      <= res[1];
      unit.unit_z      <= res[2];
      unit.unit_w      <= res[3];
      unit.zero_vector <= dv_meta.zero;
    end
  end

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    vec.valid && vec.ready |=> v1)
    else $error("accepted item did not enter first stage");
  a_zero_clears : assert property (@(posedge clk) disable iff (rst)
    unit.valid && unit.zero_vector |->
      unit.unit_x == 0 && unit.unit_y == 0 && unit.unit_z == 0 && unit.unit_w == 0)
    else $error("zero vector with nonzero components");
  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    unit.valid |-> unit.unit_x >= -16384 && unit.unit_x <= 16384)
    else $error("unit_x out of range");
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv_valid) && $stable(v2))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
